>>> src/assert_macros.svh
// Assertion helpers shared by the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/agc_pkg.sv
`default_nettype none

package agc_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 17;
    localparam int unsigned GAIN_W   = 22;
    localparam int unsigned OUT_W    = 22;
    localparam int unsigned RATE_W   = 16;
    localparam int unsigned REF_W    = 15;
    localparam int unsigned OPND_W   = 22;
    localparam int unsigned PROD_W   = 2 * OPND_W;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 48;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 22;
    localparam int unsigned STEP_W   = 27;
    localparam int unsigned SUM_W    = 28;

    localparam logic [RATE_W-1:0] ATTACK_RESET = 16'd6554;
    localparam logic [RATE_W-1:0] DECAY_RESET  = 16'd6554;
    localparam logic [REF_W-1:0]  REF_RESET    = 15'd4096;
    localparam logic [GAIN_W-1:0] MAXG_RESET   = 22'd3276800;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 22'd65536;
    localparam logic [GAIN_W-1:0] GAIN_FLOOR   = 22'd7;
    localparam logic [GAIN_W-1:0] GAIN_ONES    = 22'h3FFFFF;
    localparam logic [OUT_W-1:0]  OUT_POS_MAX  = 22'd2097151;
    localparam logic [OUT_W-1:0]  OUT_NEG_MAX  = 22'd2097152;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAXG   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SAMPLE,
        ST_ERROR,
        ST_MUL_RATE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic take;
        logic mul_en;
        logic sel_rate;
        logic err_en;
        logic upd_en;
    } seq_ctrl_t;

endpackage

`default_nettype wire

>>> src/agc_mul.sv
`default_nettype none

// Shared unsigned multiplier with a registered product.
module agc_mul
    import agc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [OPND_W-1:0] a,
    input  wire logic [OPND_W-1:0] b,
    output logic      [PROD_W-1:0] p
);

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> src/agc_seq.sv
`default_nettype none

// Sequencer: two multiplier passes per item, result held in the output register.
module agc_seq
    import agc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    input  wire logic out_busy,
    output logic      s_tready,
    output state_t    state,
    output seq_ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL_SAMPLE;
                end
            end
            ST_MUL_SAMPLE: state_next = ST_ERROR;
            ST_ERROR:      state_next = ST_MUL_RATE;
            ST_MUL_RATE:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                // hold until the output register can take the result
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.take = s_tvalid;
            end
            ST_MUL_SAMPLE: ctrl.mul_en = 1'b1;
            ST_ERROR:      ctrl.err_en = 1'b1;
            ST_MUL_RATE:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.sel_rate = 1'b1;
            end
            ST_UPDATE:     ctrl.upd_en = !out_busy;
            default:       ctrl = '0;
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

>>> src/attack_decay_agc.sv
`default_nettype none

// Attack/decay automatic gain control. Each item on s_* carries one signed
// Q4.12 sample; the block multiplies it by the stored gain (unsigned Q6.16,
// 1.0 after reset) and returns the rounded, saturated Q10.12 product together
// with the gain after this sample's update. The update subtracts error * rate
// from the gain, where error = |output| - reference_level and the rate is
// the attack rate when the error (scaled to gain units) exceeds the gain, else
// the decay rate. A gain that would go negative becomes 7 (about 1e-4), and the
// gain is clamped to the gain ceiling unless the ceiling is zero. Each item
// is processed completely before the next item can be accepted: the single
// multiplier is used twice per item (sample times gain, then error times
// rate), each pass followed by rounding and compare logic, and the
// second pass needs the first one's result. The result sits in an output
// register, so the next item is taken while the result waits; the block only
// stalls if a second result is ready before the first has been taken.
// Configuration registers may be written whenever no item is in flight.
module attack_decay_agc
    import agc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slave stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // [15:0] sample_in
    input  wire logic                  s_tlast,   // last_in_block
    // master stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,   // [21:0] sample_out, [43:22] gain_out
    output logic                       m_tlast,   // last_out
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [RATE_W-1:0] attack_reg;
    logic [RATE_W-1:0] decay_reg;
    logic [REF_W-1:0]  ref_reg;
    logic [GAIN_W-1:0] maxg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg <= ATTACK_RESET;
            decay_reg  <= DECAY_RESET;
            ref_reg    <= REF_RESET;
            maxg_reg   <= MAXG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK: attack_reg <= cfg_data[RATE_W-1:0];
                REG_DECAY:  decay_reg  <= cfg_data[RATE_W-1:0];
                REG_REF:    ref_reg    <= cfg_data[REF_W-1:0];
                REG_MAXG:   maxg_reg   <= cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    state_t    state;
    seq_ctrl_t ctrl;
    logic      out_busy;
    logic      out_valid_reg;

    assign out_busy = out_valid_reg && !m_tready;

    agc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .out_busy (out_busy),
        .s_tready (s_tready),
        .state    (state),
        .ctrl     (ctrl)
    );

    // capture the sample as sign and magnitude
    logic [MAG_W-1:0] raw_ext;
    logic [MAG_W-1:0] smag_in;
    logic [MAG_W-1:0] smag_reg;
    logic             neg_reg;
    logic             last_reg;

    assign raw_ext = {s_tdata[SAMPLE_W-1], s_tdata[SAMPLE_W-1:0]};
    assign smag_in = s_tdata[SAMPLE_W-1] ? (~raw_ext + MAG_W'(1)) : raw_ext;

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            smag_reg <= smag_in;
            neg_reg  <= s_tdata[SAMPLE_W-1];
            last_reg <= s_tlast;
        end
    end

    // shared multiplier: sample * gain first, then error * rate
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] emag_reg;
    logic              eneg_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [OPND_W-1:0] mul_a;
    logic [OPND_W-1:0] mul_b;
    logic [PROD_W-1:0] prod;

    assign mul_a = ctrl.sel_rate ? emag_reg : OPND_W'(smag_reg);
    assign mul_b = ctrl.sel_rate ? OPND_W'(rate_reg) : gain_reg;

    agc_mul u_mul (
        .clk (clk),
        .en  (ctrl.mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // error stage: round Q.28 to Q.12, saturate, form error and pick rate
    logic [OUT_W+1:0]  prod_rnd;
    logic [OUT_W-1:0]  sat_lim;
    logic [OUT_W-1:0]  omag;
    logic [OUT_W-1:0]  sample_bits;
    logic [GAIN_W-1:0] emag;
    logic              eneg;
    logic [RATE_W-1:0] rate_sel;
    logic [OUT_W-1:0]  sample_reg;

    assign prod_rnd = (OUT_W+2)'(prod[38:16]) + (OUT_W+2)'(prod[15]);
    assign sat_lim  = neg_reg ? OUT_NEG_MAX : OUT_POS_MAX;
    assign omag     = (prod_rnd > (OUT_W+2)'(sat_lim)) ? sat_lim : prod_rnd[OUT_W-1:0];
    assign sample_bits = neg_reg ? (~omag + OUT_W'(1)) : omag;
    assign eneg     = omag < OUT_W'(ref_reg);
    assign emag     = eneg ? (OUT_W'(ref_reg) - omag) : (omag - OUT_W'(ref_reg));
    assign rate_sel = ({emag, 4'b0000} > {4'b0000, gain_reg}) ? attack_reg : decay_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.err_en)
        begin
            sample_reg <= sample_bits;
            emag_reg   <= emag;
            eneg_reg   <= eneg;
            rate_reg   <= rate_sel;
        end
    end

    // update stage: round the step to Q.16, apply it, floor and clamp
    logic [STEP_W-1:0] dmag;
    logic [SUM_W-1:0]  ng;
    logic [SUM_W-1:0]  ng_clip;
    logic [GAIN_W-1:0] gain_next;

    assign dmag = STEP_W'(prod[37:12]) + STEP_W'(prod[11]);

    always_comb
    begin
        if (eneg_reg)
        begin
            ng = SUM_W'(gain_reg) + SUM_W'(dmag);
        end
        else if (SUM_W'(dmag) > SUM_W'(gain_reg))
        begin
            ng = SUM_W'(GAIN_FLOOR);
        end
        else
        begin
            ng = SUM_W'(gain_reg) - SUM_W'(dmag);
        end
        ng_clip = ng;
        if ((maxg_reg != '0) && (ng_clip > SUM_W'(maxg_reg)))
        begin
            ng_clip = SUM_W'(maxg_reg);
        end
        if (ng_clip > SUM_W'(GAIN_ONES))
        begin
            ng_clip = SUM_W'(GAIN_ONES);
        end
        gain_next = ng_clip[GAIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (ctrl.upd_en)
        begin
            gain_reg <= gain_next;
        end
    end

    // output register
    logic [M_DATA_W-1:0] tdata_reg;
    logic                tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.upd_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.upd_en)
        begin
            tdata_reg <= {(M_DATA_W-OUT_W-GAIN_W)'(0), gain_next, sample_reg};
            tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_gain_clamped, ctrl.upd_en, (maxg_reg == '0) || (gain_reg <= maxg_reg))
    `ASSERT_NEXT(a_take_starts, s_tvalid && s_tready, state == ST_MUL_SAMPLE)
    `ASSERT_NEXT(a_update_holds, (state == ST_UPDATE) && out_busy, (state == ST_UPDATE) && m_tvalid)

endmodule

`default_nettype wire
